// File: hw/rtl/ray_cone_nearest_hit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray/cone nearest-hit block
// ----------------------------------------------------------------------------
`ifndef RAY_CONE_NEAREST_HIT_DEFINES_SVH
`define RAY_CONE_NEAREST_HIT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define RCNH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rcnh assertion failed");

// next-cycle implication, disabled in reset
`define RCNH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rcnh assertion failed");

`endif

// File: hw/rtl/rcnh_pkg.sv
// ----------------------------------------------------------------------------
// rcnh_pkg
// Shared types, constants, arithmetic helpers and the micro-op program.
// ----------------------------------------------------------------------------
package rcnh_pkg;

  localparam int MAX_CONES = 256;
  localparam int CNT_W     = $clog2(MAX_CONES);
  localparam int RF_DEPTH  = 32;
  localparam int DIV_STEPS = 78;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic signed [63:0] WIDE_MAX  = 64'sh3FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] DISC_MIN  = 64'sd66;
  localparam logic signed [63:0] T_MIN     = 64'sd6554;
  localparam logic [30:0]        FAR_RESET = 31'h7FFF_FFFF;
  localparam logic [31:0]        DIRZ_RESET = 32'h0001_0000;

  // config register indexes
  localparam logic [2:0] CFG_ORG_X = 3'd0;
  localparam logic [2:0] CFG_ORG_Y = 3'd1;
  localparam logic [2:0] CFG_ORG_Z = 3'd2;
  localparam logic [2:0] CFG_DIR_X = 3'd3;
  localparam logic [2:0] CFG_DIR_Y = 3'd4;
  localparam logic [2:0] CFG_DIR_Z = 3'd5;
  localparam logic [2:0] CFG_FAR   = 3'd6;

  // opcodes
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_SQRT = 3'd4;
  localparam logic [2:0] OP_END  = 3'd5;

  // result checks
  localparam logic [1:0] CHK_NONE = 2'd0;
  localparam logic [1:0] CHK_ZERO = 2'd1;
  localparam logic [1:0] CHK_DISC = 2'd2;

  // register file slots (bit 5 clear)
  localparam logic [5:0] SL_TA   = 6'd0;
  localparam logic [5:0] SL_TB   = 6'd1;
  localparam logic [5:0] SL_LEN  = 6'd2;
  localparam logic [5:0] SL_U0   = 6'd3;
  localparam logic [5:0] SL_U1   = 6'd4;
  localparam logic [5:0] SL_U2   = 6'd5;
  localparam logic [5:0] SL_K    = 6'd6;
  localparam logic [5:0] SL_DD   = 6'd7;
  localparam logic [5:0] SL_DV   = 6'd8;
  localparam logic [5:0] SL_SV   = 6'd9;
  localparam logic [5:0] SL_DS   = 6'd10;
  localparam logic [5:0] SL_SS   = 6'd11;
  localparam logic [5:0] SL_A    = 6'd12;
  localparam logic [5:0] SL_B    = 6'd13;
  localparam logic [5:0] SL_C    = 6'd14;
  localparam logic [5:0] SL_DISC = 6'd15;
  localparam logic [5:0] SL_DEN  = 6'd16;
  localparam logic [5:0] SL_R    = 6'd17;
  localparam logic [5:0] SL_NB   = 6'd18;
  localparam logic [5:0] SL_T0   = 6'd19;
  localparam logic [5:0] SL_T1   = 6'd20;

  // preset operands (bit 5 set)
  localparam logic [5:0] P_S0   = 6'd32;
  localparam logic [5:0] P_S1   = 6'd33;
  localparam logic [5:0] P_S2   = 6'd34;
  localparam logic [5:0] P_V0   = 6'd35;
  localparam logic [5:0] P_V1   = 6'd36;
  localparam logic [5:0] P_V2   = 6'd37;
  localparam logic [5:0] P_D0   = 6'd38;
  localparam logic [5:0] P_D1   = 6'd39;
  localparam logic [5:0] P_D2   = 6'd40;
  localparam logic [5:0] P_KR   = 6'd41;
  localparam logic [5:0] P_ZERO = 6'd42;

  typedef struct packed {
    logic [2:0] op;
    logic [5:0] asrc;
    logic [5:0] bsrc;
    logic [4:0] dst;
    logic [1:0] chk;
  } uop_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic start;
    logic wr;
    logic cmp;
    logic fin;
    uop_t uop;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic reject;
    logic last;
    logic out_busy;
  } sts_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [5:0] a,
                              input logic [5:0] b, input logic [5:0] d,
                              input logic [1:0] chk);
    uop_t u;
    u.op   = op;
    u.asrc = a;
    u.bsrc = b;
    u.dst  = d[4:0];
    u.chk  = chk;
    return u;
  endfunction

  function automatic logic signed [63:0] sat65(input logic signed [64:0] x);
    if (x > 65'(WIDE_MAX)) return WIDE_MAX;
    if (x < -65'(WIDE_MAX)) return -WIDE_MAX;
    return x[63:0];
  endfunction

  function automatic logic [61:0] mag(input logic signed [63:0] x);
    logic [63:0] t;
    t = x[63] ? 64'(-x) : 64'(x);
    return t[61:0];
  endfunction

  function automatic logic signed [63:0] sx32(input logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // per-cone program: axis length, unit axis, quadratic, roots, compare
  function automatic uop_t uop_rom(input logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_MUL, P_V0, P_V0, SL_TA, CHK_NONE);
      6'd1:  u = mk(OP_MUL, P_V1, P_V1, SL_TB, CHK_NONE);
      6'd2:  u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd3:  u = mk(OP_MUL, P_V2, P_V2, SL_TB, CHK_NONE);
      6'd4:  u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd5:  u = mk(OP_SQRT, SL_TA, SL_TA, SL_LEN, CHK_ZERO);
      6'd6:  u = mk(OP_DIV, P_V0, SL_LEN, SL_U0, CHK_NONE);
      6'd7:  u = mk(OP_DIV, P_V1, SL_LEN, SL_U1, CHK_NONE);
      6'd8:  u = mk(OP_DIV, P_V2, SL_LEN, SL_U2, CHK_NONE);
      6'd9:  u = mk(OP_MUL, P_KR, P_KR, SL_K, CHK_NONE);
      // D.D
      6'd10: u = mk(OP_MUL, P_D0, P_D0, SL_TA, CHK_NONE);
      6'd11: u = mk(OP_MUL, P_D1, P_D1, SL_TB, CHK_NONE);
      6'd12: u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd13: u = mk(OP_MUL, P_D2, P_D2, SL_TB, CHK_NONE);
      6'd14: u = mk(OP_ADD, SL_TA, SL_TB, SL_DD, CHK_NONE);
      // D.U
      6'd15: u = mk(OP_MUL, P_D0, SL_U0, SL_TA, CHK_NONE);
      6'd16: u = mk(OP_MUL, P_D1, SL_U1, SL_TB, CHK_NONE);
      6'd17: u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd18: u = mk(OP_MUL, P_D2, SL_U2, SL_TB, CHK_NONE);
      6'd19: u = mk(OP_ADD, SL_TA, SL_TB, SL_DV, CHK_NONE);
      // S.U
      6'd20: u = mk(OP_MUL, P_S0, SL_U0, SL_TA, CHK_NONE);
      6'd21: u = mk(OP_MUL, P_S1, SL_U1, SL_TB, CHK_NONE);
      6'd22: u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd23: u = mk(OP_MUL, P_S2, SL_U2, SL_TB, CHK_NONE);
      6'd24: u = mk(OP_ADD, SL_TA, SL_TB, SL_SV, CHK_NONE);
      // D.S
      6'd25: u = mk(OP_MUL, P_D0, P_S0, SL_TA, CHK_NONE);
      6'd26: u = mk(OP_MUL, P_D1, P_S1, SL_TB, CHK_NONE);
      6'd27: u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd28: u = mk(OP_MUL, P_D2, P_S2, SL_TB, CHK_NONE);
      6'd29: u = mk(OP_ADD, SL_TA, SL_TB, SL_DS, CHK_NONE);
      // S.S
      6'd30: u = mk(OP_MUL, P_S0, P_S0, SL_TA, CHK_NONE);
      6'd31: u = mk(OP_MUL, P_S1, P_S1, SL_TB, CHK_NONE);
      6'd32: u = mk(OP_ADD, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd33: u = mk(OP_MUL, P_S2, P_S2, SL_TB, CHK_NONE);
      6'd34: u = mk(OP_ADD, SL_TA, SL_TB, SL_SS, CHK_NONE);
      // a
      6'd35: u = mk(OP_MUL, SL_DV, SL_DV, SL_TA, CHK_NONE);
      6'd36: u = mk(OP_SUB, SL_DD, SL_TA, SL_TA, CHK_NONE);
      6'd37: u = mk(OP_MUL, SL_K, SL_DD, SL_TB, CHK_NONE);
      6'd38: u = mk(OP_SUB, SL_TA, SL_TB, SL_A, CHK_NONE);
      // b
      6'd39: u = mk(OP_MUL, SL_DV, SL_SV, SL_TA, CHK_NONE);
      6'd40: u = mk(OP_SUB, SL_DS, SL_TA, SL_TA, CHK_NONE);
      6'd41: u = mk(OP_MUL, SL_K, SL_DS, SL_TB, CHK_NONE);
      6'd42: u = mk(OP_SUB, SL_TA, SL_TB, SL_TA, CHK_NONE);
      6'd43: u = mk(OP_ADD, SL_TA, SL_TA, SL_B, CHK_NONE);
      // c
      6'd44: u = mk(OP_MUL, SL_SV, SL_SV, SL_TA, CHK_NONE);
      6'd45: u = mk(OP_SUB, SL_SS, SL_TA, SL_TA, CHK_NONE);
      6'd46: u = mk(OP_MUL, SL_K, SL_SS, SL_TB, CHK_NONE);
      6'd47: u = mk(OP_SUB, SL_TA, SL_TB, SL_C, CHK_NONE);
      // discriminant
      6'd48: u = mk(OP_MUL, SL_A, SL_C, SL_TA, CHK_NONE);
      6'd49: u = mk(OP_ADD, SL_TA, SL_TA, SL_TA, CHK_NONE);
      6'd50: u = mk(OP_ADD, SL_TA, SL_TA, SL_TA, CHK_NONE);
      6'd51: u = mk(OP_MUL, SL_B, SL_B, SL_TB, CHK_NONE);
      6'd52: u = mk(OP_SUB, SL_TB, SL_TA, SL_DISC, CHK_DISC);
      6'd53: u = mk(OP_ADD, SL_A, SL_A, SL_DEN, CHK_ZERO);
      6'd54: u = mk(OP_SQRT, SL_DISC, SL_DISC, SL_R, CHK_NONE);
      6'd55: u = mk(OP_SUB, P_ZERO, SL_B, SL_NB, CHK_NONE);
      6'd56: u = mk(OP_SUB, SL_NB, SL_R, SL_TA, CHK_NONE);
      6'd57: u = mk(OP_DIV, SL_TA, SL_DEN, SL_T0, CHK_NONE);
      6'd58: u = mk(OP_ADD, SL_NB, SL_R, SL_TA, CHK_NONE);
      6'd59: u = mk(OP_DIV, SL_TA, SL_DEN, SL_T1, CHK_NONE);
      default: u = mk(OP_END, SL_T0, SL_T1, SL_TA, CHK_NONE);
    endcase
    return u;
  endfunction

endpackage

// File: hw/rtl/ray_cone_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_cone_nearest_hit
// One cone per item, one in work at a time: a cone that reaches the root test
// runs 27 multiplies, five divides, two square roots and 26 adds and subtracts,
// fewer when rejected early.
// The result is registered when the last cone of a scene is closed;
// reset (synchronous, rst_n low) restores the ray registers and empties the scene.
// ----------------------------------------------------------------------------
module ray_cone_nearest_hit import rcnh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic signed [31:0]  in_apex_x,
  input  logic signed [31:0]  in_apex_y,
  input  logic signed [31:0]  in_apex_z,
  input  logic signed [31:0]  in_axis_point_x,
  input  logic signed [31:0]  in_axis_point_y,
  input  logic signed [31:0]  in_axis_point_z,
  input  logic [15:0]         in_half_angle_sine,
  input  logic                in_last_cone,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit_found,
  output logic [7:0]          out_hit_index,
  output logic [30:0]         out_hit_distance
);

  cmd_t cmd;
  sts_t sts;

  rcnh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  rcnh_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_apex_x          (in_apex_x),
    .in_apex_y          (in_apex_y),
    .in_apex_z          (in_apex_z),
    .in_axis_point_x    (in_axis_point_x),
    .in_axis_point_y    (in_axis_point_y),
    .in_axis_point_z    (in_axis_point_z),
    .in_half_angle_sine (in_half_angle_sine),
    .in_last_cone       (in_last_cone),
    .cmd                (cmd),
    .sts                (sts),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_hit_found      (out_hit_found),
    .out_hit_index      (out_hit_index),
    .out_hit_distance   (out_hit_distance)
  );

endmodule

// File: hw/rtl/rcnh_ctrl.sv
// ----------------------------------------------------------------------------
// rcnh_ctrl
// Sequencer: steps the micro-op program for one cone and closes the item.
// ----------------------------------------------------------------------------
module rcnh_ctrl import rcnh_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output cmd_t cmd,
  input  sts_t sts
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_EX   = 3'd2;
  localparam logic [2:0] ST_WT   = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [5:0] pc_r, pc_nxt;
  uop_t       uop;

  assign uop      = uop_rom(pc_r);
  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    cmd       = '0;
    cmd.uop   = uop;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          pc_nxt    = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        cmd.rd    = 1'b1;
        state_nxt = (uop.op == OP_END) ? ST_CMP : ST_EX;
      end
      ST_EX: begin
        cmd.start = 1'b1;
        state_nxt = ST_WT;
      end
      ST_WT: begin
        if (sts.done) begin
          cmd.wr = 1'b1;
          if (sts.reject) begin
            state_nxt = ST_FIN;
          end else begin
            pc_nxt    = pc_r + 6'd1;
            state_nxt = ST_RD;
          end
        end
      end
      ST_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        // a final item waits until the previous result has left
        if (!(sts.last && sts.out_busy)) begin
          cmd.fin   = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pc_r    <= '0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

// File: hw/rtl/rcnh_div.sv
// ----------------------------------------------------------------------------
// rcnh_div
// Q16.16 signed divide, restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rcnh_div import rcnh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  n,
  input  logic signed [63:0]  d,
  output logic                done,
  output logic signed [63:0]  q
);

  logic                    busy_r, done_r, sgn_r;
  logic [DIV_CW-1:0]       cnt_r;
  logic [DIV_STEPS-1:0]    nq_r, nq_nxt;
  logic [61:0]             rem_r, rem_nxt, ud_r;
  logic [62:0]             rem_sh;
  logic                    qbit;
  logic [63:0]             qm;

  always_comb begin
    rem_sh = {rem_r, nq_r[DIV_STEPS-1]};
    qbit   = (rem_sh >= {1'b0, ud_r});
    rem_nxt = qbit ? 62'(rem_sh - {1'b0, ud_r}) : rem_sh[61:0];
    nq_nxt  = {nq_r[DIV_STEPS-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        nq_r   <= {mag(n), 16'b0};
        rem_r  <= '0;
        ud_r   <= mag(d);
        sgn_r  <= n[63] ^ d[63];
      end else if (busy_r) begin
        nq_r  <= nq_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign qm   = (|nq_r[DIV_STEPS-1:62]) ? 64'(WIDE_MAX) : {2'b0, nq_r[61:0]};
  assign q    = sgn_r ? -$signed(qm) : $signed(qm);
  assign done = done_r;

endmodule

// File: hw/rtl/rcnh_sqrt.sv
// ----------------------------------------------------------------------------
// rcnh_sqrt
// Q16.16 square root, digit-by-digit, one result bit per cycle.
// ----------------------------------------------------------------------------
module rcnh_sqrt import rcnh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic signed [63:0]  x,
  output logic                done,
  output logic signed [63:0]  r
);

  logic        busy_r, done_r, big_r;
  logic [63:0] x_r, res_r, bit_r, trial;
  logic [63:0] arg;
  logic        big;

  always_comb begin
    big = 1'b0;
    arg = '0;
    if (!x[63] && x != 64'sd0) begin
      big = |x[61:48];
      // large operands lose 7 result bits of precision
      arg = big ? {x[61:0], 2'b0} : {x[47:0], 16'b0};
    end
    trial = res_r + bit_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        big_r  <= big;
        x_r    <= arg;
        res_r  <= '0;
        bit_r  <= 64'h4000_0000_0000_0000;
      end else if (busy_r) begin
        if (x_r >= trial) begin
          x_r   <= x_r - trial;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign r    = big_r ? $signed(64'({res_r[31:0], 7'b0})) : $signed(64'(res_r[31:0]));
  assign done = done_r;

endmodule

// File: hw/rtl/rcnh_dp.sv
// ----------------------------------------------------------------------------
// rcnh_dp
// Datapath: ray registers, operand file, shared arithmetic, scene tracking.
// ----------------------------------------------------------------------------
module rcnh_dp import rcnh_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic signed [31:0]  in_apex_x,
  input  logic signed [31:0]  in_apex_y,
  input  logic signed [31:0]  in_apex_z,
  input  logic signed [31:0]  in_axis_point_x,
  input  logic signed [31:0]  in_axis_point_y,
  input  logic signed [31:0]  in_axis_point_z,
  input  logic [15:0]         in_half_angle_sine,
  input  logic                in_last_cone,
  input  cmd_t                cmd,
  output sts_t                sts,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_hit_found,
  output logic [7:0]          out_hit_index,
  output logic [30:0]         out_hit_distance
);

  // ray configuration
  logic [31:0] org_r [3];
  logic [31:0] dir_r [3];
  logic [30:0] far_r;

  // per-cone presets
  logic signed [63:0] s_r [3];
  logic signed [63:0] v_r [3];
  logic [16:0]        kr_r;
  logic               last_r;

  // scene state
  logic [30:0]      best_r;
  logic [7:0]       idx_r;
  logic [CNT_W-1:0] cnt_r;
  logic             any_r, open_r;

  // result channel
  logic        out_valid_r, out_found_r;
  logic [7:0]  out_index_r;
  logic [30:0] out_dist_r;

  // operand file and operand registers
  logic signed [63:0] rf [RF_DEPTH];
  logic signed [63:0] mem_a_r, mem_b_r, pre_a_r, pre_b_r;
  logic               sel_a_r, sel_b_r;
  logic signed [63:0] opa, opb;

  logic [2:0] op_r;
  logic [4:0] dst_r;
  logic [1:0] chk_r;

  // add/sub
  logic signed [63:0] alu_r;
  logic               alu_done_r;

  // multiplier: four 32x32 partial products
  logic [61:0]  ma_r, mb_r;
  logic         msgn_r, mbusy_r, mdone_r;
  logic [1:0]   mstep_r;
  logic [123:0] acc_r;
  logic [31:0]  m_ai, m_bj;
  logic [63:0]  m_prod;
  logic [1:0]   m_sh;
  logic [63:0]  mul_mag;
  logic signed [63:0] mul_res;

  logic               div_done, sqrt_done;
  logic signed [63:0] div_q, sqrt_r;
  logic signed [63:0] wb_val;
  logic               wb_done;

  logic signed [31:0] ap [3];
  logic signed [31:0] ax [3];
  logic signed [63:0] bestx;
  logic               hit0, hit1;

  assign ap[0] = in_apex_x;
  assign ap[1] = in_apex_y;
  assign ap[2] = in_apex_z;
  assign ax[0] = in_axis_point_x;
  assign ax[1] = in_axis_point_y;
  assign ax[2] = in_axis_point_z;

  function automatic logic signed [63:0] preset(input logic [5:0] src);
    case (src)
      P_S0:    return s_r[0];
      P_S1:    return s_r[1];
      P_S2:    return s_r[2];
      P_V0:    return v_r[0];
      P_V1:    return v_r[1];
      P_V2:    return v_r[2];
      P_D0:    return sx32(dir_r[0]);
      P_D1:    return sx32(dir_r[1]);
      P_D2:    return sx32(dir_r[2]);
      P_KR:    return $signed(64'(kr_r));
      default: return 64'sd0;
    endcase
  endfunction

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_r[0] <= '0;
      org_r[1] <= '0;
      org_r[2] <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DIRZ_RESET;
      far_r    <= FAR_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ORG_X: org_r[0] <= cfg_data;
        CFG_ORG_Y: org_r[1] <= cfg_data;
        CFG_ORG_Z: org_r[2] <= cfg_data;
        CFG_DIR_X: dir_r[0] <= cfg_data;
        CFG_DIR_Y: dir_r[1] <= cfg_data;
        CFG_DIR_Z: dir_r[2] <= cfg_data;
        CFG_FAR:   far_r    <= cfg_data[30:0];
        default:   ;
      endcase
    end
  end

  // item capture: differences are exact in 33 bits
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        s_r[i] <= sx32(org_r[i]) - sx32(ap[i]);
        v_r[i] <= sx32(ap[i]) - sx32(ax[i]);
      end
      kr_r   <= {in_half_angle_sine, 1'b0};
      last_r <= in_last_cone;
    end
  end

  // operand file
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      rf[dst_r] <= wb_val;
    end
    if (cmd.rd) begin
      mem_a_r <= rf[cmd.uop.asrc[4:0]];
      mem_b_r <= rf[cmd.uop.bsrc[4:0]];
      pre_a_r <= preset(cmd.uop.asrc);
      pre_b_r <= preset(cmd.uop.bsrc);
      sel_a_r <= cmd.uop.asrc[5];
      sel_b_r <= cmd.uop.bsrc[5];
    end
  end

  assign opa = sel_a_r ? pre_a_r : mem_a_r;
  assign opb = sel_b_r ? pre_b_r : mem_b_r;

  // multiplier step select
  always_comb begin
    m_ai   = mstep_r[1] ? {2'b0, ma_r[61:32]} : ma_r[31:0];
    m_bj   = mstep_r[0] ? {2'b0, mb_r[61:32]} : mb_r[31:0];
    m_prod = m_ai * m_bj;
    m_sh   = 2'(mstep_r[1] + mstep_r[0]);
    mul_mag = (|acc_r[123:78]) ? 64'(WIDE_MAX) : {2'b0, acc_r[77:16]};
    mul_res = msgn_r ? -$signed(mul_mag) : $signed(mul_mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alu_done_r <= 1'b0;
      mbusy_r    <= 1'b0;
      mdone_r    <= 1'b0;
    end else begin
      alu_done_r <= 1'b0;
      mdone_r    <= 1'b0;
      if (cmd.start) begin
        op_r  <= cmd.uop.op;
        dst_r <= cmd.uop.dst;
        chk_r <= cmd.uop.chk;
        case (cmd.uop.op)
          OP_ADD: begin
            alu_r      <= sat65({opa[63], opa} + {opb[63], opb});
            alu_done_r <= 1'b1;
          end
          OP_SUB: begin
            alu_r      <= sat65({opa[63], opa} - {opb[63], opb});
            alu_done_r <= 1'b1;
          end
          OP_MUL: begin
            ma_r    <= mag(opa);
            mb_r    <= mag(opb);
            msgn_r  <= opa[63] ^ opb[63];
            acc_r   <= '0;
            mstep_r <= '0;
            mbusy_r <= 1'b1;
          end
          default: ;
        endcase
      end else if (mbusy_r) begin
        acc_r   <= acc_r + (124'(m_prod) << {m_sh, 5'b0});
        mstep_r <= mstep_r + 2'd1;
        if (mstep_r == 2'd3) begin
          mbusy_r <= 1'b0;
          mdone_r <= 1'b1;
        end
      end
    end
  end

  rcnh_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && cmd.uop.op == OP_DIV),
    .n     (opa),
    .d     (opb),
    .done  (div_done),
    .q     (div_q)
  );

  rcnh_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start && cmd.uop.op == OP_SQRT),
    .x     (opa),
    .done  (sqrt_done),
    .r     (sqrt_r)
  );

  always_comb begin
    case (op_r)
      OP_MUL:  begin wb_val = mul_res; wb_done = mdone_r;   end
      OP_DIV:  begin wb_val = div_q;   wb_done = div_done;  end
      OP_SQRT: begin wb_val = sqrt_r;  wb_done = sqrt_done; end
      default: begin wb_val = alu_r;   wb_done = alu_done_r; end
    endcase
  end

  // root tests: root t0 first, root t1 only if t0 fails
  assign bestx = $signed({33'b0, best_r});
  assign hit0  = (opa > T_MIN) && (opa < bestx);
  assign hit1  = (opb > T_MIN) && (opb < bestx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r      <= FAR_RESET;
      idx_r       <= '0;
      cnt_r       <= '0;
      any_r       <= 1'b0;
      open_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.fin && last_r) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.load && !open_r) begin
        best_r <= far_r;
        open_r <= 1'b1;
      end
      if (cmd.cmp && (hit0 || hit1)) begin
        best_r <= hit0 ? opa[30:0] : opb[30:0];
        idx_r  <= 8'(cnt_r);
        any_r  <= 1'b1;
      end
      if (cmd.fin) begin
        if (last_r) begin
          out_found_r <= any_r;
          out_index_r <= any_r ? idx_r : 8'd0;
          out_dist_r  <= best_r;
          best_r      <= far_r;
          idx_r       <= '0;
          cnt_r       <= '0;
          any_r       <= 1'b0;
          open_r      <= 1'b0;
        end else begin
          cnt_r <= (cnt_r == CNT_W'(MAX_CONES - 1)) ? '0 : cnt_r + 1'b1;
        end
      end
    end
  end

  assign sts.done     = wb_done;
  assign sts.reject   = ((chk_r == CHK_ZERO) && (wb_val == 64'sd0)) ||
                        ((chk_r == CHK_DISC) && (wb_val < DISC_MIN));
  assign sts.last     = last_r;
  assign sts.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_hit_found    = out_found_r;
  assign out_hit_index    = out_index_r;
  assign out_hit_distance = out_dist_r;

endmodule

// File: hw/rtl/rcnh_checker.sv
// ----------------------------------------------------------------------------
// rcnh_checker
// Port-level checks on the nearest-hit block, bound to the top level.
// ----------------------------------------------------------------------------
`include "ray_cone_nearest_hit_defines.svh"

module rcnh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit_found,
  input logic [7:0]  out_hit_index,
  input logic [30:0] out_hit_distance
);

  // an accepted cone keeps the block busy for at least the next cycle
  `RCNH_ASSERT_NEXT(a_busy_after_item, in_valid && !in_stall, in_stall)

  // a miss never reports a cone index
  `RCNH_ASSERT_NOW(a_miss_index_zero, out_valid && !out_hit_found, out_hit_index == 8'd0)

  `RCNH_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)

  `RCNH_ASSERT_NEXT(a_out_stable, out_valid && out_stall,
                    $stable(out_hit_distance) && $stable(out_hit_found))

endmodule

bind ray_cone_nearest_hit rcnh_checker u_rcnh_checker (.*);
